/* hdl/battery_aware_safety_supervisor_unit_macros.svh */
// Assertion macros shared by the supervisor RTL.
// Each macro samples on the rising edge of clock.
`ifndef BATTERY_AWARE_SAFETY_SUPERVISOR_UNIT_MACROS_SVH
`define BATTERY_AWARE_SAFETY_SUPERVISOR_UNIT_MACROS_SVH

// Property checked only outside reset.
`define BASS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BASS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hdl/bass_pkg.sv */
package bass_pkg;

   // Supervisor state codes.
   localparam logic [2:0] ST_INIT      = 3'd0;
   localparam logic [2:0] ST_STANDBY   = 3'd1;
   localparam logic [2:0] ST_OPERATING = 3'd2;
   localparam logic [2:0] ST_LIMITED   = 3'd3;
   localparam logic [2:0] ST_EMERGENCY = 3'd4;
   localparam logic [2:0] ST_FAULT     = 3'd5;

   // Power mode codes.
   localparam logic [1:0] PM_NORMAL   = 2'd0;
   localparam logic [1:0] PM_ECO      = 2'd1;
   localparam logic [1:0] PM_BOOST    = 2'd2;
   localparam logic [1:0] PM_CRITICAL = 2'd3;

   // Register port geometry and register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_POWER     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ECO_POWER     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRIT_VOLTAGE  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESTOP_ENABLE  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AUTONOMOUS    = 3'd4;

   // Register reset values.
   localparam logic [15:0] MAX_POWER_RESET    = 16'd1000;
   localparam logic [15:0] ECO_POWER_RESET    = 16'd500;
   localparam logic [15:0] CRIT_VOLTAGE_RESET = 16'd40000;

   // Fixed thresholds.
   localparam logic [15:0]        ESTOP_VOLTAGE_MV = 16'd20000;
   localparam logic [9:0]         LOW_REMAIN       = 10'd50;
   localparam logic [9:0]         BOOST_REMAIN     = 10'd800;
   localparam logic signed [15:0] CHARGE_LIMIT_MA  = -16'sd100;

   // Reciprocal of five, exact for dividends below 2**22.
   localparam int unsigned  DIV5_SHIFT = 22;
   localparam logic [19:0]  DIV5_RECIP = 20'd838861;

   typedef struct packed {
      logic        manual_valid;
      logic        auto_valid;
      logic [15:0] battery_voltage_mv;
      logic signed [15:0] battery_current_ma;
      logic [9:0]  remaining_permille;
      logic        power_critical;
      logic        power_low;
      logic        chassis_good;
      logic        boom_ok;
      logic        bucket_good;
   } bass_req_type;

   typedef struct packed {
      logic [2:0]  system_state;
      logic [1:0]  pwr_mode;
      logic [16:0] budget_watts;
      logic        estop_active;
      logic        commands_enabled;
      logic        battery_healthy;
      logic        state_changed;
   } bass_rsp_type;

   // Permitted transitions between supervisor states.
   function automatic logic gate_allows(logic [2:0] from_st, logic [2:0] to_st);
      logic ok;
      case (from_st)
         ST_INIT:      ok = (to_st == ST_STANDBY) || (to_st == ST_FAULT);
         ST_STANDBY:   ok = 1'b1;
         ST_OPERATING: ok = (to_st != ST_INIT);
         ST_LIMITED:   ok = (to_st != ST_INIT);
         ST_EMERGENCY: ok = (to_st == ST_STANDBY) || (to_st == ST_FAULT);
         ST_FAULT:     ok = (to_st == ST_STANDBY) || (to_st == ST_EMERGENCY);
         default:      ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

/* hdl/bass_if.sv */
// Tick channel into the supervisor.
interface bass_req_if
   import bass_pkg::*;
();
   logic         valid;
   logic         ready;
   bass_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// Result channel out of the supervisor.
interface bass_rsp_if
   import bass_pkg::*;
();
   logic         valid;
   logic         ready;
   bass_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/battery_aware_safety_supervisor_unit.sv */
// Channel    Direction  Handshake          Beat contents
// req_ch     in         valid/ready        battery readings and health flags of one tick
// rsp_ch     out        valid/ready        state, power mode, budget and status flags
// csr_*      in         write enable only  one register write, no read-back
//
// A tick beat is registered on acceptance and evaluated from that register into
// the result register, which then offers the result on the output channel.
// One beat can be accepted every cycle unless stalled; the two registers form a pipeline.
// Reset is synchronous: non-payload registers return to defaults, the state to standby.
// A stalled result register holds the pipeline; the input side keeps taking a beat
// while its own register is empty or moving on.
`include "battery_aware_safety_supervisor_unit_macros.svh"

module battery_aware_safety_supervisor_unit
   import bass_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   bass_req_if.sink                   req_ch,
   bass_rsp_if.source                 rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   // Configuration registers.
   logic [15:0] max_power_ff;
   logic [15:0] eco_power_ff;
   logic [15:0] crit_voltage_ff;
   logic        estop_enable_ff;
   logic        autonomous_ff;

   // Pipeline registers and supervisor state.
   logic         s1_valid_ff;
   bass_req_type s1_data_ff;
   logic         rsp_valid_ff;
   bass_rsp_type rsp_data_ff;
   logic [2:0]   state_ff;
   logic [2:0]   state_in;

   // Handshake and evaluation signals.
   logic         out_free;
   logic         s1_adv;
   logic         req_take;
   logic         charging;
   logic         batt_ok;
   logic         healthy;
   logic         emerg;
   logic         present;
   logic [1:0]   mode;
   logic [18:0]  six_max;
   logic [38:0]  div_product;
   logic [16:0]  boost_budget;
   logic [16:0]  crit_budget;
   logic [16:0]  budget;
   logic [2:0]   next_state;
   logic         changed;
   bass_rsp_type rsp_in;

   // Register writes from the control port; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_power_ff    <= MAX_POWER_RESET;
         eco_power_ff    <= ECO_POWER_RESET;
         crit_voltage_ff <= CRIT_VOLTAGE_RESET;
         estop_enable_ff <= 1'b1;
         autonomous_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_POWER:    max_power_ff    <= csr_wr_data;
            CSR_ECO_POWER:    eco_power_ff    <= csr_wr_data;
            CSR_CRIT_VOLTAGE: crit_voltage_ff <= csr_wr_data;
            CSR_ESTOP_ENABLE: estop_enable_ff <= csr_wr_data[0];
            CSR_AUTONOMOUS:   autonomous_ff   <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // Pipeline flow control.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || out_free;

   // Battery and command conditions of the registered tick.
   assign charging = (s1_data_ff.battery_current_ma < CHARGE_LIMIT_MA);
   assign batt_ok  = (s1_data_ff.battery_voltage_mv > crit_voltage_ff);
   assign healthy  = s1_data_ff.chassis_good && s1_data_ff.boom_ok
                     && s1_data_ff.bucket_good && batt_ok;
   assign emerg    = (estop_enable_ff && (s1_data_ff.battery_voltage_mv < ESTOP_VOLTAGE_MV))
                     || (!batt_ok && (s1_data_ff.remaining_permille < LOW_REMAIN));
   assign present  = s1_data_ff.manual_valid || (s1_data_ff.auto_valid && autonomous_ff);

   // Power mode by priority.
   always_comb begin
      if (s1_data_ff.power_critical) begin
         mode = PM_CRITICAL;
      end else if (s1_data_ff.power_low) begin
         mode = PM_ECO;
      end else if ((s1_data_ff.remaining_permille > BOOST_REMAIN) && !charging) begin
         mode = PM_BOOST;
      end else begin
         mode = PM_NORMAL;
      end
   end

   // Boost budget is floor(6*max/5); the critical one, floor(3*max/10), is that over four.
   assign six_max      = {1'b0, max_power_ff, 2'b00} + {2'b00, max_power_ff, 1'b0};
   assign div_product  = {20'd0, six_max} * {19'd0, DIV5_RECIP};
   assign boost_budget = div_product[DIV5_SHIFT+16:DIV5_SHIFT];
   assign crit_budget  = {2'b00, boost_budget[16:2]};

   always_comb begin
      case (mode)
         PM_CRITICAL: budget = crit_budget;
         PM_ECO:      budget = {1'b0, eco_power_ff};
         PM_BOOST:    budget = boost_budget;
         default:     budget = {1'b0, max_power_ff};
      endcase
   end

   // Candidate transition by priority within each state.
   always_comb begin
      next_state = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (healthy) next_state = ST_STANDBY;
         end
         ST_STANDBY: begin
            if (present) begin
               next_state = s1_data_ff.power_critical ? ST_LIMITED : ST_OPERATING;
            end else if (emerg) begin
               next_state = ST_EMERGENCY;
            end else if (!healthy) begin
               next_state = ST_FAULT;
            end
         end
         ST_OPERATING: begin
            if (emerg) next_state = ST_EMERGENCY;
            else if (!healthy) next_state = ST_FAULT;
            else if (s1_data_ff.power_critical) next_state = ST_LIMITED;
            else if (!present) next_state = ST_STANDBY;
         end
         ST_LIMITED: begin
            if (emerg) next_state = ST_EMERGENCY;
            else if (!healthy) next_state = ST_FAULT;
            else if (!s1_data_ff.power_critical && present) next_state = ST_OPERATING;
            else if (!present) next_state = ST_STANDBY;
         end
         ST_EMERGENCY: begin
            if (!emerg && healthy) next_state = ST_STANDBY;
         end
         ST_FAULT: begin
            if (healthy) next_state = ST_STANDBY;
         end
         default: begin
            next_state = state_ff;
         end
      endcase
   end

   // The gate has the last word on a transition.
   assign changed  = (next_state != state_ff) && gate_allows(state_ff, next_state);
   assign state_in = changed ? next_state : state_ff;

   // Result beat.
   always_comb begin
      rsp_in.system_state     = state_in;
      rsp_in.pwr_mode         = mode;
      rsp_in.budget_watts     = budget;
      rsp_in.estop_active     = (state_in == ST_EMERGENCY);
      rsp_in.commands_enabled = (state_in == ST_OPERATING) || (state_in == ST_LIMITED);
      rsp_in.battery_healthy  = batt_ok;
      rsp_in.state_changed    = changed;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_STANDBY;
      end else begin
         if (req_ch.ready) s1_valid_ff <= req_ch.valid;
         if (out_free) rsp_valid_ff <= s1_valid_ff;
         if (s1_adv) state_ff <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) s1_data_ff <= req_ch.data;
      if (s1_adv) rsp_data_ff <= rsp_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Checks on the pipeline and the supervisor.
   `BASS_ASSERT_ALWAYS(a_reset_standby, $past(reset) |-> (state_ff == ST_STANDBY), "state not standby after reset")
   `BASS_ASSERT(a_state_only_on_tick, !s1_adv |=> $stable(state_ff), "state moved without a tick")
   `BASS_ASSERT(a_stall_holds_stage, (rsp_valid_ff && !rsp_ch.ready) |-> !s1_adv, "tick advanced into a stalled result")
   `BASS_ASSERT(a_emergency_exit, ($past(state_ff) == ST_EMERGENCY) |-> ((state_ff == ST_EMERGENCY) || (state_ff == ST_STANDBY) || (state_ff == ST_FAULT)), "forbidden exit from emergency")

endmodule

/* bench/tb_battery_aware_safety_supervisor_unit.sv */
module tb_battery_aware_safety_supervisor_unit
   import bass_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Register indexes from here upwards are not decoded by the block.
   localparam int unsigned CSR_UNUSED_LO = 5;
   localparam int unsigned TICKS_PER_HALF = 271;

   typedef struct {
      bass_req_type tick;
      bit           typed;
      bass_rsp_type want;
   } directed_row_type;

   typedef struct {
      logic [15:0] max_w;
      logic [15:0] eco_w;
      logic [15:0] crit_mv;
      bit          estop;
      bit          autonomous;
   } power_setting_type;

   logic clock;
   logic reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data;

   bass_req_if req_ch ();
   bass_rsp_if rsp_ch ();

   battery_aware_safety_supervisor_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Mirror of the block's registers and supervisor state.
   logic [15:0] max_power_cfg  = MAX_POWER_RESET;
   logic [15:0] eco_power_cfg  = ECO_POWER_RESET;
   logic [15:0] crit_mv_cfg    = CRIT_VOLTAGE_RESET;
   logic        estop_cfg      = 1'b1;
   logic        autonomous_cfg = 1'b0;
   logic [2:0]  supervisor_st  = ST_STANDBY;

   bass_rsp_type expected_status_q[$];
   bass_rsp_type status_want;
   int unsigned  mismatch_count = 0;
   int unsigned  idle_in_pct    = 0;
   int unsigned  idle_out_pct   = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Transitions that the supervisor lets through from each state.
   function automatic logic transition_permitted(input logic [2:0] from_st,
                                                 input logic [2:0] to_st);
      case (from_st)
         ST_INIT:                  return (to_st == ST_STANDBY) || (to_st == ST_FAULT);
         ST_STANDBY:               return 1'b1;
         ST_OPERATING, ST_LIMITED: return to_st != ST_INIT;
         ST_EMERGENCY:             return (to_st == ST_STANDBY) || (to_st == ST_FAULT);
         ST_FAULT:                 return (to_st == ST_STANDBY) || (to_st == ST_EMERGENCY);
         default:                  return 1'b0;
      endcase
   endfunction

   // Works out the status of one tick and advances the mirrored state.
   function automatic bass_rsp_type predict_supervisor_tick(input bass_req_type t);
      bass_rsp_type r;
      logic         batt_ok, healthy, emerg, present, charging;
      logic [1:0]   mode;
      int unsigned  budget;
      logic [2:0]   nxt;
      logic         changed;

      charging = $signed(t.battery_current_ma) < -100;
      batt_ok  = t.battery_voltage_mv > crit_mv_cfg;
      healthy  = t.chassis_good && t.boom_ok && t.bucket_good && batt_ok;
      emerg    = (estop_cfg && t.battery_voltage_mv < 16'd20000)
               || (!batt_ok && t.remaining_permille < 10'd50);
      present  = t.manual_valid || (t.auto_valid && autonomous_cfg);

      if (t.power_critical)
         mode = PM_CRITICAL;
      else if (t.power_low)
         mode = PM_ECO;
      else if (t.remaining_permille > 10'd800 && !charging)
         mode = PM_BOOST;
      else
         mode = PM_NORMAL;

      case (mode)
         PM_CRITICAL: budget = (int'(max_power_cfg) * 3) / 10;
         PM_ECO:      budget = int'(eco_power_cfg);
         PM_BOOST:    budget = (int'(max_power_cfg) * 6) / 5;
         default:     budget = int'(max_power_cfg);
      endcase

      nxt = supervisor_st;
      case (supervisor_st)
         ST_INIT: begin
            if (healthy) nxt = ST_STANDBY;
         end
         ST_STANDBY: begin
            if (present) nxt = t.power_critical ? ST_LIMITED : ST_OPERATING;
            else if (emerg) nxt = ST_EMERGENCY;
            else if (!healthy) nxt = ST_FAULT;
         end
         ST_OPERATING: begin
            if (emerg) nxt = ST_EMERGENCY;
            else if (!healthy) nxt = ST_FAULT;
            else if (t.power_critical) nxt = ST_LIMITED;
            else if (!present) nxt = ST_STANDBY;
         end
         ST_LIMITED: begin
            if (emerg) nxt = ST_EMERGENCY;
            else if (!healthy) nxt = ST_FAULT;
            else if (!t.power_critical && present) nxt = ST_OPERATING;
            else if (!present) nxt = ST_STANDBY;
         end
         ST_EMERGENCY: begin
            if (!emerg && healthy) nxt = ST_STANDBY;
         end
         ST_FAULT: begin
            if (healthy) nxt = ST_STANDBY;
         end
         default: ;
      endcase

      changed = (nxt != supervisor_st) && transition_permitted(supervisor_st, nxt);
      if (changed) supervisor_st = nxt;

      r.system_state     = supervisor_st;
      r.pwr_mode         = mode;
      r.budget_watts     = budget[16:0];
      r.estop_active     = supervisor_st == ST_EMERGENCY;
      r.commands_enabled = (supervisor_st == ST_OPERATING) || (supervisor_st == ST_LIMITED);
      r.battery_healthy  = batt_ok;
      r.state_changed    = changed;
      return r;
   endfunction

   function automatic bass_req_type mk_tick(input bit manual, input bit autov,
                                            input int volt, input int cur, input int rem,
                                            input bit pcrit, input bit plow,
                                            input bit chassis, input bit boom,
                                            input bit bucket);
      bass_req_type t;
      t.manual_valid       = manual;
      t.auto_valid         = autov;
      t.battery_voltage_mv = 16'(volt);
      t.battery_current_ma = 16'(cur);
      t.remaining_permille = 10'(rem);
      t.power_critical     = pcrit;
      t.power_low          = plow;
      t.chassis_good       = chassis;
      t.boom_ok            = boom;
      t.bucket_good        = bucket;
      return t;
   endfunction

   function automatic bass_rsp_type mk_status(input logic [2:0] st, input logic [1:0] mode,
                                              input int budget, input bit estop,
                                              input bit cmd, input bit batt,
                                              input bit changed);
      bass_rsp_type r;
      r.system_state     = st;
      r.pwr_mode         = mode;
      r.budget_watts     = 17'(budget);
      r.estop_active     = estop;
      r.commands_enabled = cmd;
      r.battery_healthy  = batt;
      r.state_changed    = changed;
      return r;
   endfunction

   // Mostly plausible ticks around the thresholds, with some pure noise mixed in.
   function automatic bass_req_type random_tick();
      bass_req_type t;
      int unsigned  pick;
      int unsigned  volt_lo;

      if ($urandom_range(99) < 15) begin
         t.manual_valid       = 1'($urandom);
         t.auto_valid         = 1'($urandom);
         t.battery_voltage_mv = 16'($urandom);
         t.battery_current_ma = 16'($urandom);
         t.remaining_permille = 10'($urandom);
         t.power_critical     = 1'($urandom);
         t.power_low          = 1'($urandom);
         t.chassis_good       = 1'($urandom);
         t.boom_ok            = 1'($urandom);
         t.bucket_good        = 1'($urandom);
         return t;
      end

      t.manual_valid = $urandom_range(99) < 65;
      t.auto_valid   = 1'($urandom);

      pick = $urandom_range(99);
      volt_lo = (crit_mv_cfg >= 16'd20000) ? int'(crit_mv_cfg) + 1 : 20000;
      if (pick < 8)
         t.battery_voltage_mv = 16'(20000 + $urandom_range(4) - 2);
      else if (pick < 16)
         t.battery_voltage_mv = 16'(int'(crit_mv_cfg) + $urandom_range(4) - 2);
      else if (pick < 24 || volt_lo > 65535)
         t.battery_voltage_mv = 16'($urandom);
      else
         t.battery_voltage_mv = 16'($urandom_range(65535, volt_lo));

      pick = $urandom_range(99);
      if (pick < 20)
         t.battery_current_ma = 16'(-100 + int'($urandom_range(4)) - 2);
      else if (pick < 60)
         t.battery_current_ma = 16'($urandom_range(3000));
      else
         t.battery_current_ma = 16'($urandom);

      pick = $urandom_range(99);
      if (pick < 10)
         t.remaining_permille = 10'($urandom_range(52, 48));
      else if (pick < 20)
         t.remaining_permille = 10'($urandom_range(802, 798));
      else if (pick < 45)
         t.remaining_permille = 10'($urandom_range(1000, 801));
      else
         t.remaining_permille = 10'($urandom_range(1000));

      t.power_critical = $urandom_range(99) < 10;
      t.power_low      = $urandom_range(99) < 15;
      t.chassis_good   = $urandom_range(99) < 96;
      t.boom_ok        = $urandom_range(99) < 96;
      t.bucket_good    = $urandom_range(99) < 96;
      return t;
   endfunction

   // Offers one tick beat, idling at random beforehand, and records its expected status.
   task automatic drive_tick(input bass_req_type t, input bit typed, input bass_rsp_type want);
      bass_rsp_type predicted;
      while ($urandom_range(99) < idle_in_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_supervisor_tick(t);
      expected_status_q.push_back(typed ? want : predicted);
   endtask

   // Holds back the sender until every outstanding status beat has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MAX_POWER:    max_power_cfg  = value;
         CSR_ECO_POWER:    eco_power_cfg  = value;
         CSR_CRIT_VOLTAGE: crit_mv_cfg    = value;
         CSR_ESTOP_ENABLE: estop_cfg      = value[0];
         CSR_AUTONOMOUS:   autonomous_cfg = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Single-bit registers get random upper bits, which the block must drop.
   task automatic apply_settings(input power_setting_type s);
      write_register(CSR_MAX_POWER, s.max_w);
      write_register(CSR_ECO_POWER, s.eco_w);
      write_register(CSR_CRIT_VOLTAGE, s.crit_mv);
      write_register(CSR_ESTOP_ENABLE, {15'($urandom), s.estop});
      write_register(CSR_AUTONOMOUS, {15'($urandom), s.autonomous});
      write_register(CSR_INDEX_WIDTH'($urandom_range(7, CSR_UNUSED_LO)), 16'($urandom));
   endtask

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
   endtask

   // The receiver stalls at random at the rate of the current phase.
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) rsp_ch.ready <= $urandom_range(99) >= idle_out_pct;

   // Each status beat is compared field by field with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_status_q.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: status beat with nothing expected, expected none, actual %h",
                     $time, rsp_ch.data);
         end else begin
            status_want = expected_status_q.pop_front();
            check_field("system_state", status_want.system_state, rsp_ch.data.system_state);
            check_field("pwr_mode", status_want.pwr_mode, rsp_ch.data.pwr_mode);
            check_field("budget_watts", status_want.budget_watts,
                        rsp_ch.data.budget_watts);
            check_field("estop_active", status_want.estop_active,
                        rsp_ch.data.estop_active);
            check_field("commands_enabled", status_want.commands_enabled,
                        rsp_ch.data.commands_enabled);
            check_field("battery_healthy", status_want.battery_healthy,
                        rsp_ch.data.battery_healthy);
            check_field("state_changed", status_want.state_changed,
                        rsp_ch.data.state_changed);
         end
      end
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      directed_row_type  directed_rows[$];
      power_setting_type power_settings[6];
      int unsigned       in_idle[3];
      int unsigned       out_idle[3];

      in_idle  = '{30, 59, 0};
      out_idle = '{59, 30, 0};

      power_settings[0] = '{16'd1000, 16'd500, 16'd40000, 1'b1, 1'b0};
      power_settings[1] = '{16'd65535, 16'd0, 16'd0, 1'b0, 1'b1};
      power_settings[2] = '{16'd0, 16'd65535, 16'd65535, 1'b1, 1'b1};
      power_settings[3] = '{16'($urandom), 16'($urandom), 16'($urandom_range(50000, 30000)),
                            1'b1, 1'b1};
      power_settings[4] = '{16'($urandom), 16'($urandom), 16'($urandom_range(45000, 15000)),
                            1'b0, 1'b0};
      power_settings[5] = '{16'd2500, 16'd1200, 16'd36000, 1'b1, 1'b1};

      // Walk through each state but init and edge cases from standby at reset values.
      directed_rows.push_back('{mk_tick(0, 0, 48000, 0, 500, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_STANDBY, PM_NORMAL, 1000, 0, 0, 1, 0)});
      directed_rows.push_back('{mk_tick(1, 0, 48000, 0, 500, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_OPERATING, PM_NORMAL, 1000, 0, 1, 1, 1)});
      directed_rows.push_back('{mk_tick(1, 0, 48000, 0, 1000, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_OPERATING, PM_BOOST, 1200, 0, 1, 1, 0)});
      // Just below the charging threshold boost is withheld, exactly on it boost is allowed.
      directed_rows.push_back('{mk_tick(1, 0, 48000, -101, 1000, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_OPERATING, PM_NORMAL, 1000, 0, 1, 1, 0)});
      directed_rows.push_back('{mk_tick(1, 0, 48000, -100, 1000, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_OPERATING, PM_BOOST, 1200, 0, 1, 1, 0)});
      directed_rows.push_back('{mk_tick(1, 0, 48000, 0, 500, 1, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_LIMITED, PM_CRITICAL, 300, 0, 1, 1, 1)});
      directed_rows.push_back('{mk_tick(1, 0, 48000, 0, 500, 0, 1, 1, 1, 1), 1'b1,
                                mk_status(ST_OPERATING, PM_ECO, 500, 0, 1, 1, 1)});
      directed_rows.push_back('{mk_tick(0, 0, 48000, 0, 500, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_STANDBY, PM_NORMAL, 1000, 0, 0, 1, 1)});
      // An autonomous command does not count while autonomous mode is off.
      directed_rows.push_back('{mk_tick(0, 1, 48000, 0, 800, 0, 0, 1, 1, 1), 1'b0,
                                bass_rsp_type'(0)});
      directed_rows.push_back('{mk_tick(0, 0, 48000, 0, 500, 0, 0, 0, 1, 1), 1'b1,
                                mk_status(ST_FAULT, PM_NORMAL, 1000, 0, 0, 1, 1)});
      directed_rows.push_back('{mk_tick(1, 0, 48000, 0, 500, 0, 0, 1, 0, 1), 1'b1,
                                mk_status(ST_FAULT, PM_NORMAL, 1000, 0, 0, 1, 0)});
      directed_rows.push_back('{mk_tick(0, 0, 48000, 0, 801, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_STANDBY, PM_BOOST, 1200, 0, 0, 1, 1)});
      directed_rows.push_back('{mk_tick(0, 0, 19999, 0, 500, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_EMERGENCY, PM_NORMAL, 1000, 1, 0, 0, 1)});
      directed_rows.push_back('{mk_tick(0, 0, 48000, 0, 500, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_STANDBY, PM_NORMAL, 1000, 0, 0, 1, 1)});
      // Voltage equal to the critical level is not healthy; low charge then trips emergency.
      directed_rows.push_back('{mk_tick(0, 0, 40000, 0, 49, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_EMERGENCY, PM_NORMAL, 1000, 1, 0, 0, 1)});
      directed_rows.push_back('{mk_tick(0, 0, 40001, 0, 49, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_STANDBY, PM_NORMAL, 1000, 0, 0, 1, 1)});
      // Top and bottom of every field, remaining charge above its nominal range.
      directed_rows.push_back('{mk_tick(1, 1, 65535, 32767, 1023, 1, 1, 1, 1, 1), 1'b1,
                                mk_status(ST_LIMITED, PM_CRITICAL, 300, 0, 1, 1, 1)});
      directed_rows.push_back('{mk_tick(1, 1, 0, -32768, 1023, 1, 1, 1, 1, 1), 1'b1,
                                mk_status(ST_EMERGENCY, PM_CRITICAL, 300, 1, 0, 0, 1)});
      directed_rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                                mk_status(ST_EMERGENCY, PM_NORMAL, 1000, 1, 0, 0, 0)});
      // Emergency is only left when the subsystems are healthy as well.
      directed_rows.push_back('{mk_tick(0, 0, 48000, 0, 500, 0, 0, 1, 1, 0), 1'b1,
                                mk_status(ST_EMERGENCY, PM_NORMAL, 1000, 1, 0, 1, 0)});
      directed_rows.push_back('{mk_tick(0, 0, 48000, 0, 500, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_STANDBY, PM_NORMAL, 1000, 0, 0, 1, 1)});
      directed_rows.push_back('{mk_tick(1, 0, 48000, 0, 500, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_OPERATING, PM_NORMAL, 1000, 0, 1, 1, 1)});
      directed_rows.push_back('{mk_tick(1, 0, 10000, 0, 500, 0, 0, 1, 1, 1), 1'b1,
                                mk_status(ST_EMERGENCY, PM_NORMAL, 1000, 1, 0, 0, 1)});
      directed_rows.push_back('{mk_tick(0, 0, 48000, 0, 500, 0, 1, 1, 1, 1), 1'b1,
                                mk_status(ST_STANDBY, PM_ECO, 500, 0, 0, 1, 1)});

      // Every input is known from time zero; reset is held high at the start.
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wr_data  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_in_pct  = in_idle[0];
      idle_out_pct = out_idle[0];
      foreach (directed_rows[i])
         drive_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);

      // Each idling phase runs under two register settings, written once the block is empty.
      for (int ph = 0; ph < 3; ph++) begin
         idle_in_pct  = in_idle[ph];
         idle_out_pct = out_idle[ph];
         for (int half = 0; half < 2; half++) begin
            wait_drained();
            apply_settings(power_settings[ph * 2 + half]);
            repeat (TICKS_PER_HALF) drive_tick(random_tick(), 1'b0, bass_rsp_type'(0));
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
